/* src/aes_pkg.sv */
package aes_pkg;

    localparam int NumRounds  = 10;
    localparam int RoundW     = 4;
    localparam int CfgIdxW    = 1;

    localparam logic [CfgIdxW-1:0] REG_KEY_HIGH = 1'b0;
    localparam logic [CfgIdxW-1:0] REG_KEY_LOW  = 1'b1;

    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    typedef logic [7:0]   t_byte;
    typedef logic [127:0] t_block;

    function automatic t_byte sbox(input t_byte x);
        t_byte tbl [256];
        tbl = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return tbl[x];
    endfunction

    function automatic t_byte inv_sbox(input t_byte x);
        t_byte tbl [256];
        tbl = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
        return tbl[x];
    endfunction

    function automatic t_byte xt(input t_byte x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // byte i of a block sits at bits [127-8i -: 8]
    function automatic t_byte get_b(input t_block s, input int i);
        return s[127-8*i -: 8];
    endfunction

    function automatic t_block enc_round(input t_block s, input logic last);
        t_block t, m;
        t_byte a0, a1, a2, a3;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                t[127-8*(4*c+r) -: 8] = sbox(get_b(s, 4*((c+r)%4)+r));
        m = t;
        for (int c = 0; c < 4; c++) begin
            a0 = get_b(t, 4*c); a1 = get_b(t, 4*c+1);
            a2 = get_b(t, 4*c+2); a3 = get_b(t, 4*c+3);
            m[127-8*(4*c)   -: 8] = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
            m[127-8*(4*c+1) -: 8] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
            m[127-8*(4*c+2) -: 8] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
            m[127-8*(4*c+3) -: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
        end
        return last ? t : m;
    endfunction

    function automatic t_block inv_sub_shift(input t_block s);
        t_block t;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                t[127-8*(4*((c+r)%4)+r) -: 8] = inv_sbox(get_b(s, 4*c+r));
        return t;
    endfunction

    function automatic t_block inv_mix(input t_block s);
        t_block m;
        t_byte a [4];
        t_byte x2 [4];
        t_byte x4 [4];
        t_byte x8 [4];
        for (int c = 0; c < 4; c++) begin
            for (int k = 0; k < 4; k++) begin
                a[k] = get_b(s, 4*c+k);
                x2[k] = xt(a[k]); x4[k] = xt(x2[k]); x8[k] = xt(x4[k]);
            end
            for (int r = 0; r < 4; r++)
                // coefficients 0e 0b 0d 09 rotated per row
                m[127-8*(4*c+r) -: 8] =
                    (x8[r] ^ x4[r] ^ x2[r]) ^
                    (x8[(r+1)%4] ^ x2[(r+1)%4] ^ a[(r+1)%4]) ^
                    (x8[(r+2)%4] ^ x4[(r+2)%4] ^ a[(r+2)%4]) ^
                    (x8[(r+3)%4] ^ a[(r+3)%4]);
        end
        return m;
    endfunction

    function automatic t_byte rcon(input logic [RoundW-1:0] i);
        t_byte v;
        case (i)
            4'd0: v = 8'h01;
            4'd1: v = 8'h02;
            4'd2: v = 8'h04;
            4'd3: v = 8'h08;
            4'd4: v = 8'h10;
            4'd5: v = 8'h20;
            4'd6: v = 8'h40;
            4'd7: v = 8'h80;
            4'd8: v = 8'h1b;
            4'd9: v = 8'h36;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    // next round key from previous; rc_idx is round number minus one
    function automatic t_block next_rk(input t_block k, input logic [RoundW-1:0] rc_idx);
        logic [31:0] w0, w1, w2, w3, t;
        w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
        t = {sbox(w3[23:16]) ^ rcon(rc_idx), sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
        w0 = w0 ^ t; w1 = w1 ^ w0; w2 = w2 ^ w1; w3 = w3 ^ w2;
        return {w0, w1, w2, w3};
    endfunction

endpackage

/* src/aes_rk_mem.sv */
module aes_rk_mem (
    input  logic         i_clk,
    input  logic         i_we,
    input  logic [aes_pkg::RoundW-1:0] i_waddr,
    input  logic [127:0] i_wdata,
    input  logic [aes_pkg::RoundW-1:0] i_raddr,
    output logic [127:0] o_rdata
);
    import aes_pkg::*;

    // two 64-bit halves per round key, written and read as a pair
    logic [63:0] r_hi [NumRounds+1];
    logic [63:0] r_lo [NumRounds+1];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_hi[i_waddr] <= i_wdata[127:64];
            r_lo[i_waddr] <= i_wdata[63:0];
        end
        o_rdata <= {r_hi[i_raddr], r_lo[i_raddr]};
    end
endmodule

/* src/aes128_block_cipher_top.sv */
// AES-128 ECB block cipher.
// Input words on s_axis_*: tdata = {block_low, block_high} (block_high at
// bits 63:0, block_low at 127:64), tuser = operation (0 encrypt, 1 decrypt).
// Result words on m_axis_*: tdata = {result_low, result_high}.
// Key is loaded through i_cfg_we/i_cfg_idx/i_cfg_data (0 key_high, 1 key_low).
// Each key write starts an expansion that writes the round key memory
// one round key per cycle; input is not accepted meanwhile.
// After acceptance a load state does the initial AddRoundKey, then one
// round runs per cycle through a single shared round unit (the last round
// waiting while the output register is busy), each round fed by the round
// key memory (one read per cycle, addressed in the cycle before the round).
// The unit takes a new block only once it is idle again.
// The output register holds its word while the receiver stalls; the next
// block may start meanwhile, and its last round waits until the register
// is free.
// Reset clears the key registers and control; round keys are undefined
// until the first key write.
module aes128_block_cipher_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,   // block_high[63:0], block_low[127:64]
    input  logic         s_axis_tuser,   // operation
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata,   // result_high[63:0], result_low[127:64]
    input  logic         i_cfg_we,
    input  logic [aes_pkg::CfgIdxW-1:0] i_cfg_idx,
    input  logic [63:0]  i_cfg_data
);
    import aes_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXP  = 2'd1;
    localparam logic [1:0] ST_LOAD = 2'd2;
    localparam logic [1:0] ST_RUN  = 2'd3;
    localparam logic [RoundW-1:0] LastRound = RoundW'(NumRounds);

    logic [1:0]        r_state, n_state;
    logic [63:0]       r_key_hi, r_key_lo;
    logic [RoundW-1:0] r_cnt, n_cnt;
    logic              r_op;
    t_block            r_st, n_st;
    t_block            r_rk_prev;
    logic              r_ovalid;
    t_block            r_out;

    logic              mem_we;
    logic [RoundW-1:0] mem_waddr, mem_raddr;
    t_block            mem_wdata, rk;
    t_block            new_key, in_blk, dec_step;
    logic              accept, done, out_busy, last_hold;

    assign new_key = (i_cfg_idx == REG_KEY_HIGH) ? {i_cfg_data, r_key_lo}
                                                 : {r_key_hi, i_cfg_data};
    assign in_blk  = {s_axis_tdata[63:0], s_axis_tdata[127:64]};
    assign s_axis_tready = (r_state == ST_IDLE) && !i_cfg_we;
    assign accept = s_axis_tvalid && s_axis_tready;
    // last round waits while the output register still holds an unread word
    assign out_busy  = r_ovalid && !m_axis_tready;
    assign last_hold = (r_state == ST_RUN) && (r_cnt == LastRound) && out_busy;
    assign done   = (r_state == ST_RUN) && (r_cnt == LastRound) && !out_busy;

    // key expansion writes one round key per cycle
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_cnt;
        mem_wdata = r_rk_prev;
        if (i_cfg_we && (i_cfg_idx == REG_KEY_HIGH || i_cfg_idx == REG_KEY_LOW)) begin
            mem_we    = 1'b1;
            mem_waddr = '0;
            mem_wdata = new_key;
        end else if (r_state == ST_EXP) begin
            mem_we    = 1'b1;
            mem_wdata = next_rk(r_rk_prev, r_cnt - RoundW'(1));
        end
    end

    // read address: round key for the round that runs next cycle
    always_comb begin
        if (accept)
            mem_raddr = s_axis_tuser ? LastRound : '0;
        else if (r_op == OP_DECRYPT)
            mem_raddr = LastRound - n_cnt;
        else
            mem_raddr = n_cnt;
    end

    aes_rk_mem u_rk (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_raddr(mem_raddr),
        .o_rdata(rk)
    );

    assign dec_step = inv_sub_shift(r_st) ^ rk;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_st    = r_st;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_LOAD;
                    n_st    = in_blk;
                    n_cnt   = RoundW'(1);
                end
            end
            ST_EXP: begin
                n_cnt = r_cnt + RoundW'(1);
                if (r_cnt == LastRound) n_state = ST_IDLE;
            end
            ST_LOAD: begin
                n_st    = r_st ^ rk;
                n_state = ST_RUN;
            end
            ST_RUN: begin
                if (!last_hold) begin
                    if (r_op == OP_ENCRYPT)
                        n_st = enc_round(r_st, r_cnt == LastRound) ^ rk;
                    else
                        n_st = (r_cnt == LastRound) ? dec_step : inv_mix(dec_step);
                    n_cnt = r_cnt + RoundW'(1);
                    if (done) n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
        if (i_cfg_we && (i_cfg_idx == REG_KEY_HIGH || i_cfg_idx == REG_KEY_LOW)) begin
            n_state = ST_EXP;
            n_cnt   = RoundW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= '0;
            r_key_hi <= '0;
            r_key_lo <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (i_cfg_we && i_cfg_idx == REG_KEY_HIGH) r_key_hi <= i_cfg_data;
            if (i_cfg_we && i_cfg_idx == REG_KEY_LOW)  r_key_lo <= i_cfg_data;
            if (done)
                r_ovalid <= 1'b1;
            else if (m_axis_tready)
                r_ovalid <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_st <= n_st;
        if (accept) r_op <= s_axis_tuser;
        if (mem_we) r_rk_prev <= mem_wdata;
        if (done)   r_out <= n_st;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {r_out[63:0], r_out[127:64]};

    // result is never overwritten while still waiting
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done |-> (!r_ovalid || m_axis_tready))
        else $error("result overwritten");
    // every accepted block starts by entering the load state
    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_state == ST_LOAD)
        else $error("accept did not start a block");
    // round counter stays in range while running or expanding keys
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN || r_state == ST_EXP) |-> r_cnt <= LastRound)
        else $error("round counter out of range");

endmodule

/* tb/aes128_block_cipher_top_test.sv */
`timescale 1ns / 100ps

module aes128_block_cipher_top_test;
    import aes_pkg::*;

    localparam int ClkHalf = 6;

    // one known-answer or predicted row of the directed part
    typedef struct {
        logic [63:0]  key_hi;
        logic [63:0]  key_lo;
        logic         op;
        logic [127:0] blk;
        logic         typed;
        logic [127:0] answer;
    } t_vec;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [127:0]        s_axis_tdata = '0;   // block_high[63:0], block_low[127:64]
    logic                s_axis_tuser = 1'b0; // operation
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [127:0]        m_axis_tdata;        // result_high[63:0], result_low[127:64]
    logic                i_cfg_we = 1'b0;
    logic [CfgIdxW-1:0]  i_cfg_idx = '0;
    logic [63:0]         i_cfg_data = '0;

    t_byte        fwd_sub [256];
    t_byte        rev_sub [256];
    logic [127:0] sched [11];
    logic [63:0]  cur_key_hi, cur_key_lo;
    logic [127:0] pending_blocks [$];
    int           err_count = 0;
    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;

    always #(ClkHalf) i_clk = ~i_clk;

    aes128_block_cipher_top DUT (
        .i_clk, .i_rst_n,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
        .i_cfg_we, .i_cfg_idx, .i_cfg_data
    );

    // GF(2^8) product, AES polynomial
    function automatic t_byte gf_mul(input t_byte a, input t_byte b);
        t_byte acc;
        acc = 8'h00;
        for (int k = 0; k < 8; k++) begin
            if (b[k]) acc ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
        end
        return acc;
    endfunction

    // build S-box and inverse S-box from field inverse plus affine map
    function automatic void build_sub_tables();
        t_byte inv, s;
        for (int x = 0; x < 256; x++) begin
            inv = 8'h00;
            for (int y = 1; y < 256; y++)
                if (gf_mul(x[7:0], y[7:0]) == 8'h01) inv = y[7:0];
            s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
                ^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
            fwd_sub[x] = s;
            rev_sub[s] = x[7:0];
        end
    endfunction

    // round constant: x^n in GF(2^8)
    function automatic t_byte gf_pow2(input int n);
        t_byte v;
        v = 8'h01;
        for (int k = 0; k < n; k++) v = gf_mul(v, 8'h02);
        return v;
    endfunction

    // key schedule into eleven 128-bit round keys
    function automatic void expand_schedule(input logic [127:0] key);
        t_byte w [176];
        t_byte t [4];
        t_byte first;
        for (int i = 0; i < 16; i++) w[i] = key[127-8*i -: 8];
        for (int i = 16; i < 176; i += 4) begin
            for (int j = 0; j < 4; j++) t[j] = w[i-4+j];
            if (i % 16 == 0) begin
                first = t[0];
                t[0] = fwd_sub[t[1]] ^ gf_pow2(i/16 - 1);
                t[1] = fwd_sub[t[2]];
                t[2] = fwd_sub[t[3]];
                t[3] = fwd_sub[first];
            end
            for (int j = 0; j < 4; j++) w[i+j] = w[i-16+j] ^ t[j];
        end
        for (int r = 0; r < 11; r++)
            for (int i = 0; i < 16; i++) sched[r][127-8*i -: 8] = w[16*r+i];
    endfunction

    function automatic void mix_cols(ref t_byte b [16], input t_byte coef [4]);
        t_byte col [4];
        t_byte v;
        for (int c = 0; c < 4; c++) begin
            for (int k = 0; k < 4; k++) col[k] = b[4*c+k];
            for (int r = 0; r < 4; r++) begin
                v = 8'h00;
                for (int k = 0; k < 4; k++) v ^= gf_mul(col[k], coef[(k-r+4)%4]);
                b[4*c+r] = v;
            end
        end
    endfunction

    // expected output block for one input block
    function automatic logic [127:0] cipher_block(input logic op, input logic [127:0] blk);
        t_byte b [16];
        t_byte t [16];
        t_byte coef [4];
        logic [127:0] res;
        int rk;
        for (int i = 0; i < 16; i++) b[i] = blk[127-8*i -: 8];
        if (op == OP_DECRYPT) begin
            coef = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
        end else begin
            coef = '{8'h02, 8'h03, 8'h01, 8'h01};
        end
        for (int step = 0; step <= 10; step++) begin
            if (step > 0) begin
                // substitution and row shift
                for (int c = 0; c < 4; c++)
                    for (int r = 0; r < 4; r++)
                        if (op == OP_DECRYPT)
                            t[4*((c+r)%4)+r] = rev_sub[b[4*c+r]];
                        else
                            t[4*c+r] = fwd_sub[b[4*((c+r)%4)+r]];
                b = t;
            end
            // encrypt mixes before the key, decrypt after it
            if (op == OP_ENCRYPT && step > 0 && step < 10) mix_cols(b, coef);
            rk = (op == OP_DECRYPT) ? 10 - step : step;
            for (int i = 0; i < 16; i++) b[i] ^= sched[rk][127-8*i -: 8];
            if (op == OP_DECRYPT && step > 0 && step < 10) mix_cols(b, coef);
        end
        for (int i = 0; i < 16; i++) res[127-8*i -: 8] = b[i];
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    // wait out all results plus the block latency
    task automatic settle();
        while (pending_blocks.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // idle-time write of one key register; waits out the expansion
    task automatic write_key(input logic [CfgIdxW-1:0] idx, input logic [63:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == REG_KEY_HIGH) cur_key_hi = val;
        else cur_key_lo = val;
        expand_schedule({cur_key_hi, cur_key_lo});
        repeat (16) @(posedge i_clk);
    endtask

    // present one word, hold until accepted, queue its expected result
    task automatic send_block(input logic op, input logic [127:0] blk,
                              input logic typed, input logic [127:0] answer);
        if ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {blk[63:0], blk[127:64]};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_blocks.push_back(typed ? answer : cipher_block(op, blk));
    endtask

    // receiver back-pressure
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // result check against oldest expectation
    always @(posedge i_clk) begin
        logic [127:0] want;
        if (m_axis_tvalid && m_axis_tready) begin
            if (pending_blocks.size() == 0) begin
                report_mismatch("unexpected word", m_axis_tdata[63:0], '0);
            end else begin
                want = pending_blocks.pop_front();
                if (m_axis_tdata[63:0] !== want[127:64])
                    report_mismatch("result_high", m_axis_tdata[63:0], want[127:64]);
                if (m_axis_tdata[127:64] !== want[63:0])
                    report_mismatch("result_low", m_axis_tdata[127:64], want[63:0]);
            end
        end
    end

    initial begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        t_vec         vectors [$];
        logic [63:0]  kh, kl;
        logic [127:0] blk;
        int           pick;

        // known answers and field extremes
        vectors = '{
            '{64'h0001020304050607, 64'h08090a0b0c0d0e0f, OP_ENCRYPT,
              128'h00112233445566778899aabbccddeeff, 1'b1,
              128'h69c4e0d86a7b0430d8cdb78070b4c55a},
            '{64'h0001020304050607, 64'h08090a0b0c0d0e0f, OP_DECRYPT,
              128'h69c4e0d86a7b0430d8cdb78070b4c55a, 1'b1,
              128'h00112233445566778899aabbccddeeff},
            '{64'h0001020304050607, 64'h08090a0b0c0d0e0f, OP_ENCRYPT, '0, 1'b0, '0},
            '{64'h0001020304050607, 64'h08090a0b0c0d0e0f, OP_DECRYPT, '1, 1'b0, '0},
            '{64'h0001020304050607, 64'h08090a0b0c0d0e0f, OP_ENCRYPT, '1, 1'b0, '0},
            '{64'h0001020304050607, 64'h08090a0b0c0d0e0f, OP_DECRYPT, '0, 1'b0, '0},
            '{64'h0, 64'h0, OP_ENCRYPT, '0, 1'b1, 128'h66e94bd4ef8a2c3b884cfa59ca342b2e},
            '{64'h0, 64'h0, OP_DECRYPT, 128'h66e94bd4ef8a2c3b884cfa59ca342b2e, 1'b1, '0},
            '{64'h0, 64'h0, OP_ENCRYPT, {64'h8000000000000000, 64'h1}, 1'b0, '0},
            '{64'h0, 64'h0, OP_DECRYPT, {64'h1, 64'h8000000000000000}, 1'b0, '0},
            '{'1, '1, OP_ENCRYPT, '0, 1'b0, '0},
            '{'1, '1, OP_ENCRYPT, '1, 1'b0, '0},
            '{'1, '1, OP_DECRYPT, '1, 1'b0, '0},
            '{'1, '1, OP_DECRYPT, 128'h5555aaaa5555aaaa5555aaaa5555aaaa, 1'b0, '0},
            '{'1, 64'h0, OP_ENCRYPT, 128'haaaa5555aaaa5555aaaa5555aaaa5555, 1'b0, '0},
            '{'1, 64'h0, OP_DECRYPT, 128'h0f0f0f0f0f0f0f0ff0f0f0f0f0f0f0f0, 1'b0, '0}
        };

        build_sub_tables();
        cur_key_hi = '0;
        cur_key_lo = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);
        write_key(REG_KEY_HIGH, vectors[0].key_hi);
        write_key(REG_KEY_LOW, vectors[0].key_lo);

        // directed part; key changes only at drained boundaries
        foreach (vectors[i]) begin
            if (vectors[i].key_hi !== cur_key_hi || vectors[i].key_lo !== cur_key_lo) begin
                s_axis_tvalid <= 1'b0;
                settle();
                if (vectors[i].key_hi !== cur_key_hi) write_key(REG_KEY_HIGH, vectors[i].key_hi);
                if (vectors[i].key_lo !== cur_key_lo) write_key(REG_KEY_LOW, vectors[i].key_lo);
            end
            send_block(vectors[i].op, vectors[i].blk, vectors[i].typed, vectors[i].answer);
        end

        // random part: nine key phases, three idling regimes
        for (int phase = 0; phase < 9; phase++) begin
            case (phase / 3)
                0: begin send_idle_pct = 18; recv_idle_pct = 83; end
                1: begin send_idle_pct = 83; recv_idle_pct = 18; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            s_axis_tvalid <= 1'b0;
            settle();
            kh = {$urandom, $urandom};
            kl = {$urandom, $urandom};
            pick = phase % 4;
            // extremes, then partial updates of a single register
            if (phase == 1) begin kh = '1; kl = '1; end
            if (phase == 4) begin kh = '0; kl = '0; end
            if (pick == 2) write_key(REG_KEY_LOW, kl);
            else if (pick == 3) write_key(REG_KEY_HIGH, kh);
            else begin
                write_key(REG_KEY_HIGH, kh);
                write_key(REG_KEY_LOW, kl);
            end
            for (int n = 0; n < 100; n++) begin
                blk = {$urandom, $urandom, $urandom, $urandom};
                send_block(1'($urandom_range(1)), blk, 1'b0, '0);
            end
        end

        s_axis_tvalid <= 1'b0;
        settle();
        if (err_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
